// ----- sv/pcwp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcwp_pkg
// Shared constants, register indexes, configuration type and back-end states
// for the corridor wall point generator.
// ----------------------------------------------------------------------------
`default_nettype none
package pcwp_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int STEP_MAX_DEF    = 1023;

	localparam int REG_WALL_SPAN   = 0;
	localparam int REG_SAMPLE_STEP = 1;

	localparam logic [30:0] WALL_SPAN_RESET   = 31'd131072;
	localparam logic [9:0]  SAMPLE_STEP_RESET = 10'd5;

	localparam int NORM_BIT   = 29;
	localparam int ROOT_ITERS = 32;
	localparam int DIV_ITERS  = 32;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [30:0] wall_span;
		logic [9:0]  sample_step;
	} cfg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_NORM,
		B_SQX,
		B_SQY,
		B_SUM,
		B_ROOT,
		B_MULX,
		B_MULY,
		B_NUMY,
		B_DIV,
		B_LEFT,
		B_RIGHT
	} back_state_t;
endpackage
`default_nettype wire

// ----- sv/pcwp_if.sv -----
// ----------------------------------------------------------------------------
// pcwp_pose_if / pcwp_wall_if
// Valid/ready channels for path poses and wall points.
// ----------------------------------------------------------------------------
`default_nettype none
interface pcwp_pose_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pose_x;
	logic signed [COORD_WIDTH-1:0] pose_y;
	logic                          last_pose;
	modport source (output valid, pose_x, pose_y, last_pose, input ready);
	modport sink (input valid, pose_x, pose_y, last_pose, output ready);
endinterface

interface pcwp_wall_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] wall_x;
	logic signed [COORD_WIDTH-1:0] wall_y;
	logic                          wall_side;
	logic                          last_point;
	modport source (output valid, wall_x, wall_y, wall_side, last_point, input ready);
	modport sink (input valid, wall_x, wall_y, wall_side, last_point, output ready);
endinterface
`default_nettype wire

// ----- sv/pcwp_queue.sv -----
// ----------------------------------------------------------------------------
// pcwp_queue
// Small register FIFO of wall jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module pcwp_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   full,
	output logic                   empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ----- sv/pcwp_front.sv -----
// ----------------------------------------------------------------------------
// pcwp_front
// Accepts poses, tracks sample state and issues nonzero wall jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module pcwp_front #(
	parameter int COORD_WIDTH = 32,
	parameter int STEP_MAX    = 1023,
	parameter int JOB_W       = 1 + 4 * COORD_WIDTH + 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pcwp_pkg::cfg_t cfg,
	pcwp_pose_if.sink          pose,
	input  wire logic          q_full,
	output logic               q_push,
	output logic [JOB_W-1:0]   q_data
);
	import pcwp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int SW = $clog2(STEP_MAX + 1);
	localparam int EW = ((SW > 10) ? SW : 10) + 1;
	localparam int PW = (STEP_MAX > 1) ? $clog2(STEP_MAX) : 1;

	logic signed [CW-1:0] sx_q, sy_q, ax_q, ay_q, vx_q, vy_q;
	logic [PW-1:0]        phase_q;
	logic                 have_s_q, have_a_q, have_p_q;
	logic [JOB_W-1:0]     pend_q;
	logic                 pend_v_q;

	logic                 acc, p0, last, a_ok, b_ok;
	logic signed [CW:0]   adx, ady, bdx, bdy;
	logic signed [CW-1:0] bpx, bpy, ex, ey;
	logic [JOB_W-1:0]     job_a, job_b;
	logic [EW-1:0]        step_eff, ph_inc;

	assign pose.ready = !pend_v_q && !q_full;
	assign acc  = pose.valid && pose.ready;
	assign p0   = (phase_q == '0);
	assign last = pose.last_pose;

	always_comb begin
		step_eff = EW'(cfg.sample_step);
		if (step_eff == '0) step_eff = EW'(1);
		if (step_eff > EW'(STEP_MAX)) step_eff = EW'(STEP_MAX);
		ph_inc = EW'(phase_q) + 1'b1;

		adx = {pose.pose_x[CW-1], pose.pose_x} - {sx_q[CW-1], sx_q};
		ady = {pose.pose_y[CW-1], pose.pose_y} - {sy_q[CW-1], sy_q};
		a_ok = p0 && have_s_q && ((adx != '0) || (ady != '0));

		ex = have_a_q ? ax_q : pose.pose_x;
		ey = have_a_q ? ay_q : pose.pose_y;
		if (p0) begin
			bpx = pose.pose_x;
			bpy = pose.pose_y;
			bdx = {pose.pose_x[CW-1], pose.pose_x} - {vx_q[CW-1], vx_q};
			bdy = {pose.pose_y[CW-1], pose.pose_y} - {vy_q[CW-1], vy_q};
			b_ok = last && have_p_q && ((bdx != '0) || (bdy != '0));
		end else begin
			bpx = sx_q;
			bpy = sy_q;
			bdx = {ex[CW-1], ex} - {sx_q[CW-1], sx_q};
			bdy = {ey[CW-1], ey} - {sy_q[CW-1], sy_q};
			b_ok = last && have_s_q && ((bdx != '0) || (bdy != '0));
		end
		job_a = {last && !b_ok, sx_q, sy_q, adx, ady};
		job_b = {1'b1, bpx, bpy, bdx, bdy};

		q_push = 1'b0;
		q_data = job_a;
		if (pend_v_q) begin
			q_push = !q_full;
			q_data = pend_q;
		end else if (acc) begin
			q_push = a_ok || b_ok;
			q_data = a_ok ? job_a : job_b;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (p0) begin
				sx_q <= pose.pose_x;
				sy_q <= pose.pose_y;
			end else if (have_s_q && !have_a_q) begin
				ax_q <= pose.pose_x;
				ay_q <= pose.pose_y;
			end
			if (!last) begin
				vx_q <= pose.pose_x;
				vy_q <= pose.pose_y;
			end
			pend_q <= job_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			have_s_q <= 1'b0;
			have_a_q <= 1'b0;
			have_p_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (pend_v_q && !q_full) pend_v_q <= 1'b0;
			if (acc) begin
				pend_v_q <= a_ok && b_ok;
				if (last) begin
					phase_q  <= '0;
					have_s_q <= 1'b0;
					have_a_q <= 1'b0;
					have_p_q <= 1'b0;
				end else begin
					if (p0) begin
						have_s_q <= 1'b1;
						have_a_q <= 1'b0;
					end else if (have_s_q) begin
						have_a_q <= 1'b1;
					end
					have_p_q <= 1'b1;
					phase_q  <= (ph_inc >= step_eff) ? '0 : PW'(ph_inc);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/pcwp_back.sv -----
// ----------------------------------------------------------------------------
// pcwp_back
// Normalizes a job direction and emits its left and right wall points.
// ----------------------------------------------------------------------------
`default_nettype none
module pcwp_back #(
	parameter int COORD_WIDTH = 32,
	parameter int JOB_W       = 1 + 4 * COORD_WIDTH + 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pcwp_pkg::cfg_t cfg,
	input  wire logic           q_empty,
	input  wire logic [JOB_W-1:0] q_data,
	output logic                q_pop,
	pcwp_wall_if.source         wall
);
	import pcwp_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int AW   = ((CW + 1) > 31) ? (CW + 1) : 31;
	localparam int SUMW = ((CW > 32) ? CW : 32) + 2;
	localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

	back_state_t state_q, state_d;

	logic                 j_last;
	logic signed [CW-1:0] j_px, j_py;
	logic signed [CW:0]   j_dx, j_dy;
	assign {j_last, j_px, j_py, j_dx, j_dy} = q_data;

	logic signed [CW-1:0] px_q, py_q;
	logic                 negx_q, negy_q, last_q;
	logic [AW-1:0]        ax_q, ay_q, mx;
	logic [61:0]          prod_q, prod, numx, numy;
	logic [62:0]          v_q, r_q, bit_q, rb;
	logic [4:0]           cnt_q;
	logic [31:0]          remx_q, remy_q, qx_q, qy_q, dvs_q;
	logic [32:0]          rem2x, rem2y;
	logic                 gex, gey;
	logic [30:0]          mul_a, mul_b;
	logic                 out_free;
	logic signed [SUMW-1:0] psx, psy, ofx, ofy, lx, ly, rx, ry;

	function automatic logic signed [CW-1:0] sat(input logic signed [SUMW-1:0] v);
		if (v > SAT_HI) return CW'(SAT_HI);
		if (v < SAT_LO) return CW'(SAT_LO);
		return CW'(v);
	endfunction

	always_comb begin
		mx  = (ax_q > ay_q) ? ax_q : ay_q;
		rb  = r_q + bit_q;
		rem2x = {remx_q, qx_q[31]};
		rem2y = {remy_q, qy_q[31]};
		gex = (rem2x >= {1'b0, dvs_q});
		gey = (rem2y >= {1'b0, dvs_q});
		mul_a = ax_q[30:0];
		mul_b = ax_q[30:0];
		case (state_q)
			B_SQY: begin
				mul_a = ay_q[30:0];
				mul_b = ay_q[30:0];
			end
			B_MULX: mul_b = cfg.wall_span;
			B_MULY: begin
				mul_a = ay_q[30:0];
				mul_b = cfg.wall_span;
			end
			default: ;
		endcase
		prod = 62'(mul_a) * 62'(mul_b);
		numx = prod_q + 62'(r_q[31:0]);
		numy = numx;
		psx = SUMW'(px_q);
		psy = SUMW'(py_q);
		ofx = negx_q ? -SUMW'(qx_q) : SUMW'(qx_q);
		ofy = negy_q ? -SUMW'(qy_q) : SUMW'(qy_q);
		lx  = psx - ofy;
		ly  = psy + ofx;
		rx  = psx + ofy;
		ry  = psy - ofx;
	end

	assign out_free = !wall.valid || wall.ready;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			B_IDLE: if (!q_empty) begin
				q_pop   = 1'b1;
				state_d = B_NORM;
			end
			B_NORM: if ((mx >> 30) == '0 && mx[NORM_BIT]) state_d = B_SQX;
			B_SQX:  state_d = B_SQY;
			B_SQY:  state_d = B_SUM;
			B_SUM:  state_d = B_ROOT;
			B_ROOT: if (cnt_q == '0) state_d = B_MULX;
			B_MULX: state_d = B_MULY;
			B_MULY: state_d = B_NUMY;
			B_NUMY: state_d = B_DIV;
			B_DIV:  if (cnt_q == '0) state_d = B_LEFT;
			B_LEFT: if (out_free) state_d = B_RIGHT;
			B_RIGHT: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				px_q   <= j_px;
				py_q   <= j_py;
				last_q <= j_last;
				negx_q <= j_dx[CW];
				negy_q <= j_dy[CW];
				ax_q   <= AW'(j_dx[CW] ? $unsigned(-j_dx) : $unsigned(j_dx));
				ay_q   <= AW'(j_dy[CW] ? $unsigned(-j_dy) : $unsigned(j_dy));
			end
			B_NORM: begin
				if ((mx >> 30) != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (!mx[NORM_BIT]) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			B_SQX: prod_q <= prod;
			B_SQY: begin
				prod_q <= prod;
				v_q    <= 63'(prod_q);
			end
			B_SUM: begin
				v_q   <= v_q + 63'(prod_q);
				r_q   <= '0;
				bit_q <= 63'(1) << 62;
				cnt_q <= 5'(ROOT_ITERS - 1);
			end
			B_ROOT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 1'b1;
			end
			B_MULX: prod_q <= prod;
			B_MULY: begin
				prod_q <= prod;
				remx_q <= 32'(numx[61:32]);
				qx_q   <= numx[31:0];
				dvs_q  <= {r_q[30:0], 1'b0};
			end
			B_NUMY: begin
				remy_q <= 32'(numy[61:32]);
				qy_q   <= numy[31:0];
				cnt_q  <= 5'(DIV_ITERS - 1);
			end
			B_DIV: begin
				remx_q <= gex ? 32'(rem2x - {1'b0, dvs_q}) : rem2x[31:0];
				remy_q <= gey ? 32'(rem2y - {1'b0, dvs_q}) : rem2y[31:0];
				qx_q   <= {qx_q[30:0], gex};
				qy_q   <= {qy_q[30:0], gey};
				cnt_q  <= cnt_q - 1'b1;
			end
			B_LEFT: if (out_free) begin
				wall.wall_x     <= sat(lx);
				wall.wall_y     <= sat(ly);
				wall.wall_side  <= 1'b0;
				wall.last_point <= 1'b0;
			end
			B_RIGHT: if (out_free) begin
				wall.wall_x     <= sat(rx);
				wall.wall_y     <= sat(ry);
				wall.wall_side  <= 1'b1;
				wall.last_point <= last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall.valid <= 1'b0;
		end else begin
			if ((state_q == B_LEFT || state_q == B_RIGHT) && out_free) wall.valid <= 1'b1;
			else if (wall.ready) wall.valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- sv/path_corridor_wall_points.sv -----
// ----------------------------------------------------------------------------
// path_corridor_wall_points
// Samples path poses and emits corridor wall points on both sides.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  pose    | in  | pose_x, pose_y, last_pose
//  wall    | out | wall_x, wall_y, wall_side, last_point
//  apb     | in  | wall span (0x0), sample_step (0x4)
//
// A pose that yields two wall jobs leaves the second waiting in the front.
// Each job in the back passes through a one-bit-per-cycle normalizing
// shift, a 32-step square root and a 32-step divider pair.
// A four-entry job queue parts front and back; pose ready drops while the
// queue is full or a second job of the same pose waits.
// Reset restores the register defaults and clears all path state.
`default_nettype none
module path_corridor_wall_points #(
	parameter int COORD_WIDTH = pcwp_pkg::COORD_WIDTH_DEF,
	parameter int STEP_MAX    = pcwp_pkg::STEP_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pcwp_pose_if.sink        pose,
	pcwp_wall_if.source      wall,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pcwp_pkg::*;

	localparam int JOB_W = 1 + 4 * COORD_WIDTH + 2;

	cfg_t             cfg_q;
	logic             q_push, q_pop, q_full, q_empty;
	logic [JOB_W-1:0] q_wdata, q_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(REG_SAMPLE_STEP)) ? {22'd0, cfg_q.sample_step}
	                                                  : {1'b0, cfg_q.wall_span};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_span   <= WALL_SPAN_RESET;
			cfg_q.sample_step <= SAMPLE_STEP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == 1'(REG_SAMPLE_STEP)) cfg_q.sample_step <= pwdata[9:0];
			else if (paddr[2] == 1'(REG_WALL_SPAN))
				cfg_q.wall_span <= pwdata[30:0];
		end
	end

	pcwp_front #(.COORD_WIDTH(COORD_WIDTH), .STEP_MAX(STEP_MAX), .JOB_W(JOB_W)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pose   (pose),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	pcwp_queue #(.DATA_W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	pcwp_back #(.COORD_WIDTH(COORD_WIDTH), .JOB_W(JOB_W)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.wall    (wall)
	);
endmodule
`default_nettype wire

// ----- sim/pcwp_wall_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcwp_wall_checker
// Watches the pose, wall and register ports of the corridor wall point
// generator, predicts the wall points of every accepted pose and compares
// each wall beat, field by field, against the oldest predicted point.
// ----------------------------------------------------------------------------
`default_nettype none
module pcwp_wall_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pcwp_pose_if             pose,
	pcwp_wall_if             wall,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending,
	output int               points
);
	import pcwp_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               side;
		logic               last;
	} wall_pt_t;

	localparam longint COORD_HI = 64'sd2147483647;
	localparam longint COORD_LO = -64'sd2147483648;

	wall_pt_t wall_q[$];
	wall_pt_t batch[$];

	logic [30:0] cw;
	logic [9:0]  step_reg;
	longint      samp_x, samp_y, aft_x, aft_y, prev_x, prev_y;
	int          phase;
	bit          has_samp, has_aft, has_prev;

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp(longint v);
		if (v > COORD_HI)
			return COORD_HI[31:0];
		if (v < COORD_LO)
			return COORD_LO[31:0];
		return v[31:0];
	endfunction

	task automatic add_wall_pair(longint px, longint py, longint dx, longint dy);
		longint unsigned ax, ay, m, nrm, ox, oy;
		longint sx, sy;
		wall_pt_t pt;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax == 0 && ay == 0)
			return;
		m = ax > ay ? ax : ay;
		while (m >= (64'd1 << 30)) begin
			ax >>= 1; ay >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			ax <<= 1; ay <<= 1; m <<= 1;
		end
		nrm = int_root(ax * ax + ay * ay);
		ox = (ax * cw + nrm) / (2 * nrm);
		oy = (ay * cw + nrm) / (2 * nrm);
		sx = dx < 0 ? -longint'(ox) : longint'(ox);
		sy = dy < 0 ? -longint'(oy) : longint'(oy);
		pt.x = clamp(px - sy); pt.y = clamp(py + sx); pt.side = 0; pt.last = 0;
		batch.insert(batch.size(), pt);
		pt.x = clamp(px + sy); pt.y = clamp(py - sx); pt.side = 1;
		batch.insert(batch.size(), pt);
	endtask

	task automatic predict_pose(longint cx, longint cy, bit last);
		int stp;
		stp = step_reg == 0 ? 1 : int'(step_reg);
		if (stp > STEP_MAX_DEF)
			stp = STEP_MAX_DEF;
		batch.delete();
		if (phase == 0) begin
			if (has_samp)
				add_wall_pair(samp_x, samp_y, cx - samp_x, cy - samp_y);
			samp_x = cx; samp_y = cy;
			has_samp = 1;
			has_aft = 0;
		end else if (has_samp && !has_aft) begin
			aft_x = cx; aft_y = cy;
			has_aft = 1;
		end
		if (last) begin
			if (phase == 0) begin
				if (has_prev)
					add_wall_pair(cx, cy, cx - prev_x, cy - prev_y);
			end else if (has_samp && has_aft) begin
				add_wall_pair(samp_x, samp_y, aft_x - samp_x, aft_y - samp_y);
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1;
			phase = 0;
			has_samp = 0; has_aft = 0; has_prev = 0;
		end else begin
			prev_x = cx; prev_y = cy;
			has_prev = 1;
			phase = (phase + 1 >= stp) ? 0 : phase + 1;
		end
		foreach (batch[i])
			wall_q.insert(wall_q.size(), batch[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		wall_pt_t exp_pt;
		if (!arst_n) begin
			cw = WALL_SPAN_RESET;
			step_reg = SAMPLE_STEP_RESET;
			phase = 0;
			has_samp = 0; has_aft = 0; has_prev = 0;
			samp_x = 0; samp_y = 0; aft_x = 0; aft_y = 0; prev_x = 0; prev_y = 0;
			wall_q.delete();
			pending = 0;
			errors = 0;
			points = 0;
		end else begin
			if (wall.valid && wall.ready) begin
				points++;
				if (wall_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected wall beat x=%0d y=%0d side=%0b last=%0b",
						$time, wall.wall_x, wall.wall_y, wall.wall_side, wall.last_point);
				end else begin
					exp_pt = wall_q.pop_front();
					if (wall.wall_x !== exp_pt.x || wall.wall_y !== exp_pt.y ||
					    wall.wall_side !== exp_pt.side || wall.last_point !== exp_pt.last) begin
						errors++;
						$display("%0t: wall mismatch expected x=%0d y=%0d side=%0b last=%0b",
							$time, exp_pt.x, exp_pt.y, exp_pt.side, exp_pt.last);
						$display("%0t:                 actual x=%0d y=%0d side=%0b last=%0b",
							$time, wall.wall_x, wall.wall_y, wall.wall_side, wall.last_point);
					end
				end
			end
			if (pose.valid && pose.ready)
				predict_pose(longint'(pose.pose_x), longint'(pose.pose_y), pose.last_pose);
			if (psel && penable && pwrite && pready) begin
				if (paddr >> 2 == REG_WALL_SPAN)
					cw = pwdata[30:0];
				else if (paddr >> 2 == REG_SAMPLE_STEP)
					step_reg = pwdata[9:0];
			end
			pending = wall_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- sim/path_corridor_wall_points_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_corridor_wall_points_test
// Drives paths of poses through the corridor wall point generator under
// several corridor widths and sample steps, with random idling on both
// channels and one long wall stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module path_corridor_wall_points_test;
	import pcwp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors, pending, points;
	int          poses_sent;
	int          cfg_writes;
	bit          calm;
	bit          stall_go;

	pcwp_pose_if pose_ch ();
	pcwp_wall_if wall_ch ();

	path_corridor_wall_points dut (
		.clk(clk), .arst_n(arst_n), .pose(pose_ch), .wall(wall_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pcwp_wall_checker chk (
		.clk(clk), .arst_n(arst_n), .pose(pose_ch), .wall(wall_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending), .points(points)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	// wall side: random hold-offs plus one long stall
	initial begin
		int hold_left;
		bit stall_done;
		hold_left = 0;
		stall_done = 0;
		wall_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_go && !stall_done) begin
				stall_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				wall_ch.ready <= 1'b0;
			end else begin
				wall_ch.ready <= calm || $urandom_range(99) >= 31;
			end
		end
	end

	task automatic reg_write(int idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cfg_writes++;
	endtask

	task automatic send_pose(logic [31:0] x, logic [31:0] y, bit last);
		while (!calm && $urandom_range(99) < 31) begin
			pose_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pose_ch.valid <= 1'b1;
		pose_ch.pose_x <= x;
		pose_ch.pose_y <= y;
		pose_ch.last_pose <= last;
		@(posedge clk);
		while (!pose_ch.ready) @(posedge clk);
		poses_sent++;
	endtask

	task automatic drain_then_config(logic [31:0] width, logic [31:0] stp);
		pose_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		reg_write(REG_WALL_SPAN, width);
		reg_write(REG_SAMPLE_STEP, stp);
	endtask

	function automatic logic [31:0] pick_coord(int mode);
		case (mode)
			0: return 32'($urandom_range(0, 2 << 20)) - 32'(1 << 20);
			1: return $urandom;
			default: return $urandom_range(1) ? 32'h7FFF_FF00 + $urandom_range(255)
			                                     : 32'h8000_0000 + $urandom_range(255);
		endcase
	endfunction

	// path of len poses; small moves, wild jumps, repeated poses or extremes
	task automatic send_path(int len, int mode, bit close);
		logic [31:0] x, y;
		x = pick_coord(mode == 1 ? 1 : (mode == 3 ? 2 : 0));
		y = pick_coord(mode == 1 ? 1 : (mode == 3 ? 2 : 0));
		for (int i = 0; i < len; i++) begin
			send_pose(x, y, close && i == len - 1);
			case (mode)
				0: begin
					x += 32'($urandom_range(0, 8192)) - 32'd4096;
					y += 32'($urandom_range(0, 8192)) - 32'd4096;
				end
				1: begin
					x = $urandom; y = $urandom;
				end
				2: if ($urandom_range(1)) begin
					x += 32'($urandom_range(2)) - 32'd1;
				end
				default: begin
					x = pick_coord(2); y = pick_coord(2);
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		paddr <= '0; pwdata <= '0;
		pose_ch.valid <= 1'b0;
		pose_ch.pose_x <= '0; pose_ch.pose_y <= '0; pose_ch.last_pose <= 1'b0;
		poses_sent = 0;
		cfg_writes = 0;
		calm = 0;
		stall_go = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, default registers: lone pose, short path, repeated pose
		send_pose(32'd100, 32'd200, 1'b1);
		send_pose(32'h0001_0000, 32'h0, 1'b0);
		send_pose(32'h0003_0000, 32'h0, 1'b1);
		send_pose(32'h10, 32'h10, 1'b0);
		send_pose(32'h10, 32'h10, 1'b1);
		// extremes and saturation, widest corridor, step of one
		drain_then_config(32'h7FFF_FFFF, 32'd1);
		send_pose(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_pose(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_pose(32'h8000_0000, 32'h8000_0000, 1'b1);
		// zero width, step of zero, masked upper bits
		drain_then_config(32'h8000_0000, 32'hFFFF_FC00);
		send_pose(32'h0, 32'h0, 1'b0);
		send_pose(32'h1, 32'hFFFF_FFFF, 1'b0);
		send_pose(32'h5, 32'h5, 1'b1);
		// narrowest nonzero corridor, largest step: sample looks at the next pose
		drain_then_config(32'd1, 32'd1023);
		send_pose(32'h0, 32'h0, 1'b0);
		send_pose(32'h0002_0000, 32'hFFFF_0000, 1'b0);
		send_pose(32'h0004_0000, 32'h0, 1'b1);
		// step change within an open path
		drain_then_config(32'h0002_0000, 32'd3);
		send_path(4, 0, 1'b0);
		drain_then_config(32'h0003_0000, 32'd2);
		send_path(5, 0, 1'b1);

		while (poses_sent < 420) begin
			int mode;
			if (poses_sent >= 200 && poses_sent < 280)
				calm = 1;
			else
				calm = 0;
			if (poses_sent >= 120)
				stall_go = 1;
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(4))
					0: drain_then_config(32'h7FFF_FFFF, 32'($urandom_range(1, 4)));
					1: drain_then_config(32'($urandom_range(1, 16)), 32'($urandom_range(1, 3)));
					2: drain_then_config($urandom, 32'($urandom_range(0, 1023)));
					default: drain_then_config(32'($urandom_range(1, 32'h80000)),
					                           32'($urandom_range(1, 6)));
				endcase
			end
			mode = $urandom_range(99) < 70 ? 0 : $urandom_range(1, 3);
			send_path($urandom_range(1, 14), mode, $urandom_range(9) != 0);
		end
		send_path(2, 0, 1'b1);

		pose_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		$display("ran %0d poses through %0d register writes, %0d wall points checked",
			poses_sent, cfg_writes, points);
		$display("paths covered small moves, wide jumps, zero moves and saturating extremes");
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
